// ===== rtl/frame_deframer_sequence_tracker_top_macros.svh =====
// Assertion macros used by the sequence tracker RTL.
`ifndef FRAME_DEFRAMER_SEQUENCE_TRACKER_TOP_MACROS_SVH
`define FRAME_DEFRAMER_SEQUENCE_TRACKER_TOP_MACROS_SVH
`ifndef SYNTH
`define FDST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define FDST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define FDST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FDST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/fdst_pkg.sv =====
// Shared constants, register indexes and types of the frame deframer and sequence tracker.
package fdst_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned ID_FIELD_W  = 16;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned TAB_W       = 32;
	localparam int unsigned MISSED_W    = 6;
	localparam int unsigned GAP_LIMIT_W = 6;
	localparam int unsigned WINDOW_W    = 8;
	localparam int unsigned POS_W       = 4;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam int unsigned DEF_ID_MODULUS = 64;

	localparam logic [BYTE_W-1:0] SYM_STX = 8'h02;
	localparam logic [BYTE_W-1:0] SYM_ETX = 8'h03;
	localparam logic [BYTE_W-1:0] SYM_ESC = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;
	localparam logic [POS_W-1:0]  FULL_LEN = 4'd8;

	localparam logic [GAP_LIMIT_W-1:0] RST_RESTART_GAP_LIMIT = 6'd5;
	localparam logic [WINDOW_W-1:0]    RST_RESYNC_WINDOW     = 8'd10;

	localparam logic [CFG_IDX_W-1:0] REG_RESTART_GAP_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESYNC_WINDOW     = 1'd1;

	typedef struct packed {
		logic [ID_FIELD_W-1:0] id;
		logic [COUNT_W-1:0]    count;
		logic [TAB_W-1:0]      tab;
	} fdst_frame_t;

endpackage

// ===== rtl/fdst_ifs.sv =====
// Valid/ready channel interfaces for received bytes and for frame results.
interface fdst_rx_if import fdst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              chunk_last;
	logic [TAB_W-1:0]  tab_number;

	modport source (output valid, output rx_byte, output chunk_last, output tab_number,
		input ready);
	modport sink (input valid, input rx_byte, input chunk_last, input tab_number,
		output ready);
endinterface

interface fdst_res_if import fdst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ID_FIELD_W-1:0] frame_id;
	logic [COUNT_W-1:0]    encoder_count;
	logic [MISSED_W-1:0]   missed_ids;
	logic [TAB_W-1:0]      running_total;
	logic                  first_id_seen;
	logic                  sequence_restart;
	logic                  id_out_of_range;

	modport source (output valid, output frame_id, output encoder_count, output missed_ids,
		output running_total, output first_id_seen, output sequence_restart,
		output id_out_of_range, input ready);
	modport sink (input valid, input frame_id, input encoder_count, input missed_ids,
		input running_total, input first_id_seen, input sequence_restart,
		input id_out_of_range, output ready);
endinterface

// ===== rtl/fdst_deframer.sv =====
// Byte unstuffing and frame assembly stage with input and frame-event registers.
module fdst_deframer import fdst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fdst_rx_if.sink     rx,
	output logic        frame_valid,
	output fdst_frame_t frame,
	input  logic        frame_ready
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic [TAB_W-1:0]  tab_s1;

	logic                  in_frame_q;
	logic                  esc_q;
	logic [POS_W-1:0]      pos_q;
	logic [ID_FIELD_W-1:0] id_q;
	logic [COUNT_W-1:0]    cnt_q;

	logic        frame_valid_s2;
	fdst_frame_t frame_s2;

	logic                  in_frame_d;
	logic                  esc_d;
	logic [POS_W-1:0]      pos_d;
	logic [ID_FIELD_W-1:0] id_d;
	logic [COUNT_W-1:0]    cnt_d;

	logic              is_stx;
	logic              is_etx;
	logic              frame_done;
	logic              s2_free;
	logic              s1_go;
	logic              s1_fire;
	logic              take;
	logic [BYTE_W-1:0] dec_byte;

	assign is_stx     = (byte_s1 == SYM_STX);
	assign is_etx     = in_frame_q && (byte_s1 == SYM_ETX);
	assign frame_done = valid_s1 && !is_stx && is_etx && (pos_q >= FULL_LEN);
	assign s2_free    = !frame_valid_s2 || frame_ready;
	assign s1_go      = !frame_done || s2_free;
	assign s1_fire    = valid_s1 && s1_go;
	assign rx.ready   = !valid_s1 || s1_go;

	assign dec_byte = esc_q ? (byte_s1 ^ ESC_XOR) : byte_s1;
	assign take     = in_frame_q && !is_stx && !is_etx && (esc_q || (byte_s1 != SYM_ESC));

	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		pos_d      = pos_q;
		id_d       = id_q;
		cnt_d      = cnt_q;
		if (is_stx) begin
			in_frame_d = 1'b1;
			esc_d      = 1'b0;
			id_d       = '0;
			cnt_d      = '0;
			pos_d      = POS_W'(1);
		end else if (is_etx) begin
			in_frame_d = 1'b0;
			esc_d      = 1'b0;
		end else if (in_frame_q) begin
			esc_d = !esc_q && (byte_s1 == SYM_ESC);
		end
		if (take && (pos_q < FULL_LEN)) begin
			case (pos_q)
				4'd2: id_d[7:0]    = dec_byte;
				4'd3: id_d[15:8]   = dec_byte;
				4'd4: cnt_d[7:0]   = dec_byte;
				4'd5: cnt_d[15:8]  = dec_byte;
				4'd6: cnt_d[23:16] = dec_byte;
				4'd7: cnt_d[31:24] = dec_byte;
				default: ;
			endcase
			pos_d = pos_q + POS_W'(1);
		end
		if (last_s1) begin
			in_frame_d = 1'b0;
			esc_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			in_frame_q     <= 1'b0;
			esc_q          <= 1'b0;
			pos_q          <= '0;
			id_q           <= '0;
			cnt_q          <= '0;
			frame_valid_s2 <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (s1_fire) begin
				in_frame_q <= in_frame_d;
				esc_q      <= esc_d;
				pos_q      <= pos_d;
				id_q       <= id_d;
				cnt_q      <= cnt_d;
			end
			if (s2_free) begin
				frame_valid_s2 <= frame_done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.chunk_last;
			tab_s1  <= rx.tab_number;
		end
		if (frame_done && s2_free) begin
			frame_s2.id    <= id_q;
			frame_s2.count <= cnt_q;
			frame_s2.tab   <= tab_s1;
		end
	end

	assign frame_valid = frame_valid_s2;
	assign frame       = frame_s2;

endmodule

// ===== rtl/fdst_tracker.sv =====
// Sequence tracking, tab total resync and the result register.
`include "frame_deframer_sequence_tracker_top_macros.svh"
module fdst_tracker import fdst_pkg::*; #(
	parameter int unsigned ID_MODULUS = DEF_ID_MODULUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  frame_valid,
	input  fdst_frame_t           frame,
	output logic                  frame_ready,
	fdst_res_if.source            res
);

	localparam int unsigned ID_W = (ID_MODULUS > 1) ? $clog2(ID_MODULUS) : 1;
	localparam logic [ID_FIELD_W:0] MOD_EXT = (ID_FIELD_W+1)'(ID_MODULUS);
	localparam logic [ID_W:0]       MOD_W1  = (ID_W+1)'(ID_MODULUS);

	logic [GAP_LIMIT_W-1:0] gap_limit_q;
	logic [WINDOW_W-1:0]    window_q;
	logic [ID_W-1:0]        exp_id_q;
	logic                   exp_valid_q;
	logic [TAB_W-1:0]       total_q;

	logic                  out_valid_q;
	logic [ID_FIELD_W-1:0] id_q;
	logic [COUNT_W-1:0]    count_q;
	logic [MISSED_W-1:0]   missed_q;
	logic [TAB_W-1:0]      running_q;
	logic                  first_q;
	logic                  restart_q;
	logic                  oor_q;

	logic                  go;
	logic                  fire;
	logic [TAB_W-1:0]      d_raw;
	logic                  neg_side;
	logic                  resync;
	logic [TAB_W-1:0]      base;
	logic                  oor;
	logic [ID_W-1:0]       id_n;
	logic [ID_W:0]         diff;
	logic [ID_W:0]         wrapped;
	logic                  gap_case;
	logic [ID_W-1:0]       missed;
	logic [ID_FIELD_W:0]   missed_ext;
	logic                  restart;
	logic [TAB_W-1:0]      gap_add;
	logic [TAB_W-1:0]      total_new;
	logic [ID_FIELD_W:0]   id_inc;
	logic [ID_W-1:0]       next_exp;

	assign go          = !out_valid_q || res.ready;
	assign fire        = frame_valid && go;
	assign frame_ready = go;

	// Shorter distance around the 32-bit circle compared against the window.
	assign d_raw    = total_q - frame.tab;
	assign neg_side = d_raw[TAB_W-1] && (d_raw[TAB_W-2:0] != '0);
	assign resync   = neg_side ? (~d_raw >= TAB_W'(window_q)) : (d_raw > TAB_W'(window_q));
	assign base     = resync ? frame.tab : total_q;

	assign oor      = ({1'b0, frame.id} >= MOD_EXT);
	assign id_n     = frame.id[ID_W-1:0];
	assign diff     = {1'b0, id_n} - {1'b0, exp_id_q};
	assign wrapped  = diff[ID_W] ? (diff + MOD_W1) : diff;
	assign gap_case = exp_valid_q && !oor && (id_n != exp_id_q);
	assign missed   = gap_case ? wrapped[ID_W-1:0] : '0;
	assign missed_ext = (ID_FIELD_W+1)'(missed);
	assign restart  = gap_case && (frame.id == '0)
		&& (missed_ext > (ID_FIELD_W+1)'(gap_limit_q));
	assign gap_add  = (gap_case && !restart) ? TAB_W'(missed) : '0;
	assign total_new = base + gap_add + TAB_W'(1);

	assign id_inc   = {1'b0, frame.id} + (ID_FIELD_W+1)'(1);
	assign next_exp = (id_inc >= MOD_EXT) ? '0 : id_inc[ID_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= RST_RESTART_GAP_LIMIT;
			window_q    <= RST_RESYNC_WINDOW;
			exp_id_q    <= '0;
			exp_valid_q <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RESTART_GAP_LIMIT: gap_limit_q <= cfg_wdata[GAP_LIMIT_W-1:0];
					REG_RESYNC_WINDOW:     window_q    <= cfg_wdata[WINDOW_W-1:0];
					default: ;
				endcase
			end
			if (go) begin
				out_valid_q <= frame_valid;
			end
			if (fire) begin
				exp_id_q    <= next_exp;
				exp_valid_q <= 1'b1;
				total_q     <= total_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			id_q      <= frame.id;
			count_q   <= frame.count;
			missed_q  <= missed_ext[MISSED_W-1:0];
			running_q <= total_new;
			first_q   <= !exp_valid_q;
			restart_q <= restart;
			oor_q     <= oor;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.frame_id         = id_q;
	assign res.encoder_count    = count_q;
	assign res.missed_ids       = missed_q;
	assign res.running_total    = running_q;
	assign res.first_id_seen    = first_q;
	assign res.sequence_restart = restart_q;
	assign res.id_out_of_range  = oor_q;

	`FDST_ASSERT_IMP(a_restart_zero_id, clk, arst_n, res.valid && res.sequence_restart, res.frame_id == '0)
	`FDST_ASSERT_IMP(a_first_no_gap, clk, arst_n, res.valid && res.first_id_seen, res.missed_ids == '0 && !res.sequence_restart)
	`FDST_ASSERT_IMP(a_oor_no_gap, clk, arst_n, res.valid && res.id_out_of_range, res.missed_ids == '0 && !res.sequence_restart)
	`FDST_ASSERT_NXT(a_fire_loads, clk, arst_n, frame_valid && frame_ready, res.valid && exp_valid_q)

endmodule

// ===== rtl/frame_deframer_sequence_tracker_top.sv =====
// Top level of the STX/ETX byte-stuffed deframer with ID sequence and tab total tracking.
//
// The rx channel takes one raw stream byte per item, with a chunk-end flag and the
// application's current tab number. The res channel gives one item for every frame
// that closes with ETX after at least seven decoded bytes; all other bytes give none.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while the block is idle, as the block itself does not enforce it.
//
// Throughput is one byte per cycle while rx is not stalled. After the closing ETX is
// accepted, the result passes through the input register, where the unstuffing and
// frame state update happens, and the frame register, where the ID gap and the resync
// of the running total are worked out, before it reaches the result register on res.
//
// Reset clears the frame state, the expected ID and the running total, and restores
// the restart gap limit to 5 and the resync window to 10. When res stalls, the
// result register holds its item; bytes that close no frame keep flowing, and rx
// stalls only once a finished frame waits in the frame register as well.
module frame_deframer_sequence_tracker_top import fdst_pkg::*; #(
	parameter int unsigned ID_MODULUS = DEF_ID_MODULUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	fdst_rx_if.sink               rx,
	fdst_res_if.source            res
);

	logic        frame_valid;
	logic        frame_ready;
	fdst_frame_t frame;

	fdst_deframer u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.frame_valid (frame_valid),
		.frame       (frame),
		.frame_ready (frame_ready)
	);

	fdst_tracker #(
		.ID_MODULUS (ID_MODULUS)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.frame_valid (frame_valid),
		.frame       (frame),
		.frame_ready (frame_ready),
		.res         (res)
	);

endmodule
